// ===== rtl/mts_pkg.sv =====
`default_nettype none

package mts_pkg;

    // Fixed field widths
    localparam int MODE_W     = 2;
    localparam int SLOT_W     = 6;
    localparam int PITCH_W    = 16;
    localparam int LENGTH_W   = 16;
    localparam int TIME_W     = 32;
    localparam int CMPV_W     = 8;
    localparam int SONG_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Divider geometry
    localparam int DIV_W = 16;
    localparam int CNT_W = 4;

    localparam int DEF_TABLE_DEPTH = 64;

    // Item codes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_CLOCK  = 1'd1;

    // Reset values of configuration, and fixed divider and compare constants
    localparam logic [SONG_W-1:0]  SONG_LENGTH_RST = 7'd1;
    localparam logic [DIV_W-1:0]   TONE_CLOCK_RST  = 16'd31256;
    localparam logic [DIV_W-1:0]   GAP_DIVISOR     = 16'd3;
    localparam logic [CMPV_W-1:0]  CMPV_MAX        = 8'hFF;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    // Clamp a quotient to the compare register range
    function automatic logic [CMPV_W-1:0] sat_cmpv(input logic [DIV_W-1:0] q);
        logic [CMPV_W-1:0] r;
        if (q[DIV_W-1:CMPV_W] != '0)
            r = CMPV_MAX;
        else
            r = q[CMPV_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mts_div.sv =====
`default_nettype none

module mts_div (
    input  wire                        clk,
    input  wire                        rst_n,
    input  mts_pkg::div_req_t          req,
    output logic                       done,
    output logic [mts_pkg::DIV_W-1:0]  quotient
);
    import mts_pkg::*;

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quot_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (req.go)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(DIV_W - 1);
            rem_next  = '0;
            quot_next = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/melody_tone_sequencer.sv =====
`default_nettype none

// Channel   Signals                                        Handshake
// -------   --------------------------------------------   ------------------------------
// item in   mode entry_index entry_pitch entry_length       transfer on start && !busy
//           now_ms
// result    tone_enable timer_running compare_value         one-cycle strobe on done,
//           note_index changed                               no back-pressure
// config    cfg_index cfg_data                              transfer on cfg_valid && cfg_ready
//
// A result follows evaluation alone for load, stop, unused codes and idle ticks, a table read
// for a zero-pitch tone, the divider for a gap, both for a tone (shared 16-step divider).
// busy stays high through the done cycle; the next item transfers in the cycle after done at best.
// Reset clears all control state; the note table holds no reset value and needs no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.

module melody_tone_sequencer #(
    parameter int TABLE_DEPTH = mts_pkg::DEF_TABLE_DEPTH
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire  [mts_pkg::MODE_W-1:0]        mode,
    input  wire  [mts_pkg::SLOT_W-1:0]        entry_index,
    input  wire  [mts_pkg::PITCH_W-1:0]       entry_pitch,
    input  wire  [mts_pkg::LENGTH_W-1:0]      entry_length,
    input  wire  [mts_pkg::TIME_W-1:0]        now_ms,
    output logic                              done,
    output logic                              tone_enable,
    output logic                              timer_running,
    output logic [mts_pkg::CMPV_W-1:0]        compare_value,
    output logic [mts_pkg::SLOT_W-1:0]        note_index,
    output logic                              changed,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mts_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mts_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    // Common width for index compares: holds the table depth and the song length
    localparam int CMP_W = (IDX_W + 1 > SONG_W) ? IDX_W + 1 : SONG_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_READ = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Held item fields
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [PITCH_W-1:0]  pitch_reg, pitch_next;
    logic [LENGTH_W-1:0] length_reg, length_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    // Player state
    logic [TIME_W-1:0]   start_time_reg, start_time_next;
    logic [LENGTH_W-1:0] dur_reg, dur_next;
    logic                in_tone_reg, in_tone_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                output_on_reg, output_on_next;
    logic                clock_on_reg, clock_on_next;
    logic [CMPV_W-1:0]   cmpv_reg, cmpv_next;
    logic                changed_reg, changed_next;

    // Configuration
    logic [SONG_W-1:0]   song_len_reg;
    logic [DIV_W-1:0]    tone_clk_reg;

    // Note table
    logic [31:0]         table_mem [TABLE_DEPTH];
    logic [31:0]         rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [CMP_W-1:0]    slot_ext;
    logic                slot_ok;

    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    idx_plus;
    logic [IDX_W-1:0]    idx_after_tone;
    logic [IDX_W-1:0]    idx_after_gap;
    logic [TIME_W-1:0]   elapsed;
    logic                due;

    div_req_t            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;

    mts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // Index wrap: back to zero at or beyond the song length or the table depth
    assign idx_ext  = CMP_W'(idx_reg);
    assign idx_plus = idx_ext + 1'b1;
    assign idx_after_tone = ((idx_plus >= CMP_W'(song_len_reg)) ||
                             (idx_plus >= CMP_W'(TABLE_DEPTH))) ? '0 : idx_plus[IDX_W-1:0];
    assign idx_after_gap  = ((idx_ext >= CMP_W'(song_len_reg)) ||
                             (idx_ext >= CMP_W'(TABLE_DEPTH))) ? '0 : idx_reg;

    // Wrapping time difference against the current duration
    assign elapsed = now_reg - start_time_reg;
    assign due     = (elapsed >= TIME_W'(dur_reg));

    // Loads beyond the table are dropped
    assign slot_ext  = CMP_W'(slot_reg);
    assign slot_ok   = (slot_ext < CMP_W'(TABLE_DEPTH));
    assign mem_waddr = slot_ext[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        pitch_next      = pitch_reg;
        length_next     = length_reg;
        now_next        = now_reg;
        start_time_next = start_time_reg;
        dur_next        = dur_reg;
        in_tone_next    = in_tone_reg;
        idx_next        = idx_reg;
        output_on_next  = output_on_reg;
        clock_on_next   = clock_on_reg;
        cmpv_next       = cmpv_reg;
        changed_next    = changed_reg;
        mem_we          = 1'b0;
        div_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Hold the item fields for the whole run
                if (start)
                begin
                    mode_next   = mode;
                    slot_next   = entry_index;
                    pitch_next  = entry_pitch;
                    length_next = entry_length;
                    now_next    = now_ms;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                changed_next = 1'b0;
                state_next   = S_DONE;
                unique case (mode_reg)
                    MODE_LOAD:
                    begin
                        mem_we = slot_ok;
                    end
                    MODE_TICK:
                    begin
                        if (due)
                        begin
                            if (in_tone_reg)
                            begin
                                // Gap: one third of the previous duration
                                div_req.go       = 1'b1;
                                div_req.dividend = dur_reg;
                                div_req.divisor  = GAP_DIVISOR;
                                state_next       = S_DIV;
                            end
                            else
                            begin
                                // Table read addressed by the play index this cycle
                                state_next = S_READ;
                            end
                        end
                    end
                    MODE_STOP:
                    begin
                        output_on_next = 1'b0;
                        clock_on_next  = 1'b0;
                    end
                    default:
                    begin
                        // Unused code: report the state, change nothing
                    end
                endcase
            end
            S_READ:
            begin
                if (rd_data_reg[PITCH_W-1:0] == '0)
                begin
                    // Zero pitch: tone with the largest compare value, no division
                    clock_on_next   = 1'b1;
                    output_on_next  = 1'b1;
                    cmpv_next       = CMPV_MAX;
                    dur_next        = rd_data_reg[31:16];
                    in_tone_next    = 1'b1;
                    idx_next        = idx_after_tone;
                    start_time_next = now_reg;
                    changed_next    = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    div_req.go       = 1'b1;
                    div_req.dividend = tone_clk_reg;
                    div_req.divisor  = rd_data_reg[PITCH_W-1:0];
                    state_next       = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (in_tone_reg)
                    begin
                        output_on_next = 1'b0;
                        in_tone_next   = 1'b0;
                        dur_next       = div_q;
                        idx_next       = idx_after_gap;
                    end
                    else
                    begin
                        clock_on_next  = 1'b1;
                        output_on_next = 1'b1;
                        cmpv_next      = sat_cmpv(div_q);
                        dur_next       = rd_data_reg[31:16];
                        in_tone_next   = 1'b1;
                        idx_next       = idx_after_tone;
                    end
                    start_time_next = now_reg;
                    changed_next    = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            start_time_reg <= '0;
            dur_reg        <= '0;
            in_tone_reg    <= 1'b0;
            idx_reg        <= '0;
            output_on_reg  <= 1'b0;
            clock_on_reg   <= 1'b0;
            cmpv_reg       <= '0;
            changed_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_time_reg <= start_time_next;
            dur_reg        <= dur_next;
            in_tone_reg    <= in_tone_next;
            idx_reg        <= idx_next;
            output_on_reg  <= output_on_next;
            clock_on_reg   <= clock_on_next;
            cmpv_reg       <= cmpv_next;
            changed_reg    <= changed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        slot_reg   <= slot_next;
        pitch_reg  <= pitch_next;
        length_reg <= length_next;
        now_reg    <= now_next;
    end

    // Configuration registers: written on each config transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_len_reg <= SONG_LENGTH_RST;
            tone_clk_reg <= TONE_CLOCK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SONG_LENGTH: song_len_reg <= cfg_data[SONG_W-1:0];
                REG_TONE_CLOCK:  tone_clk_reg <= cfg_data[DIV_W-1:0];
            endcase
        end
    end

    // Note table: pitch in the low half, length in the high half
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= {length_reg, pitch_reg};
        end
        rd_data_reg <= table_mem[idx_reg];
    end

    assign cfg_ready     = 1'b1;
    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign tone_enable   = output_on_reg;
    assign timer_running = clock_on_reg;
    assign compare_value = cmpv_reg;
    assign note_index    = idx_ext[SLOT_W-1:0];
    assign changed       = changed_reg;

    // The play index never leaves the table
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_ext < CMP_W'(TABLE_DEPTH))
        else $error("play index beyond table depth");

    // The output pin is only driven while the timer clock runs
    a_out_needs_clk: assert property (@(posedge clk) disable iff (!rst_n)
        output_on_reg |-> clock_on_reg)
        else $error("tone enabled with timer stopped");

    // A reported change always flips between tone and gap
    a_change_flips: assert property (@(posedge clk) disable iff (!rst_n)
        (done && changed) |-> (in_tone_reg != $past(in_tone_reg)))
        else $error("change reported without tone/gap toggle");

    // The divider only finishes while the sequencer waits for it
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider result outside divide state");

endmodule

`default_nettype wire
